@@ hdl/lcal_pkg.sv @@
`default_nettype none

package lcal_pkg;

   localparam int NODES    = 4096;
   localparam int LEVELS   = 12;
   localparam int NODE_W   = 12;
   localparam int DEPTH_W  = 12;
   localparam int LVL_W    = $clog2(LEVELS);
   localparam int NODE_AW  = $clog2(NODES);
   localparam int ANC_SIZE = NODES * LEVELS;
   localparam int ANC_AW   = $clog2(ANC_SIZE);
   localparam int PC_W     = 5;

   // Read port selection for one microcode step.
   typedef enum logic [2:0] {
      RD_NONE,
      RD_NODE_A,
      RD_NODE_B,
      RD_ANC_A,
      RD_ANC_B,
      RD_PAR_A
   } rd_type;

   // Write port selection for one microcode step.
   typedef enum logic [1:0] {
      WR_NONE,
      WR_ANC_B,
      WR_ANC_RD,
      WR_NODE
   } wr_type;

   // Datapath register update for one microcode step.
   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LATCH_A,
      ACT_LATCH_B,
      ACT_LVL_INC,
      ACT_B_FROM_RD,
      ACT_RES_INS,
      ACT_ORDER,
      ACT_LIFT_TEST,
      ACT_LIFT_TAKE,
      ACT_LVL_TOP,
      ACT_CA_LATCH,
      ACT_MOVE,
      ACT_LVL_DEC,
      ACT_RES_PARENT,
      ACT_RES_A,
      ACT_RES_ERR
   } act_type;

   // Jump condition for one microcode step.
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_IS_QUERY,
      C_ERR_INS,
      C_ERR_QRY,
      C_LVL_NOT_LAST,
      C_CLR_MORE,
      C_MORE,
      C_A_EQ_B,
      C_SKIP,
      C_LVL_NZ
   } cond_type;

   typedef struct packed {
      rd_type            rd;
      wr_type            wr;
      act_type           act;
      cond_type          cond;
      logic [PC_W-1:0]   target;
      logic              fin;
   } uword_type;

   typedef struct packed {
      logic is_query;
      logic err_ins;
      logic err_qry;
      logic lvl_not_last;
      logic clr_more;
      logic more;
      logic a_eq_b;
      logic skip;
      logic lvl_nz;
      logic out_free;
   } flags_type;

   localparam uword_type UW_NOP = '{
      rd: RD_NONE, wr: WR_NONE, act: ACT_NONE, cond: C_NEVER, target: '0, fin: 1'b0
   };

   // Program addresses.
   localparam logic [PC_W-1:0] S_FETCH_A  = PC_W'(0);
   localparam logic [PC_W-1:0] S_FETCH_B  = PC_W'(1);
   localparam logic [PC_W-1:0] S_SPLIT    = PC_W'(2);
   localparam logic [PC_W-1:0] S_I_CHECK  = PC_W'(3);
   localparam logic [PC_W-1:0] S_I_ROOT   = PC_W'(4);
   localparam logic [PC_W-1:0] S_I_READ   = PC_W'(5);
   localparam logic [PC_W-1:0] S_I_WRITE  = PC_W'(6);
   localparam logic [PC_W-1:0] S_I_FINISH = PC_W'(7);
   localparam logic [PC_W-1:0] S_Q_CHECK  = PC_W'(8);
   localparam logic [PC_W-1:0] S_L_TEST   = PC_W'(9);
   localparam logic [PC_W-1:0] S_L_TAKE   = PC_W'(10);
   localparam logic [PC_W-1:0] S_P_EQ     = PC_W'(11);
   localparam logic [PC_W-1:0] S_P_TEST   = PC_W'(12);
   localparam logic [PC_W-1:0] S_P_READ_B = PC_W'(13);
   localparam logic [PC_W-1:0] S_P_CMP    = PC_W'(14);
   localparam logic [PC_W-1:0] S_P_NEXT   = PC_W'(15);
   localparam logic [PC_W-1:0] S_P_PAR    = PC_W'(16);
   localparam logic [PC_W-1:0] S_P_RES    = PC_W'(17);
   localparam logic [PC_W-1:0] S_R_SAME   = PC_W'(18);
   localparam logic [PC_W-1:0] S_R_ERR    = PC_W'(19);
   localparam logic [PC_W-1:0] S_DONE     = PC_W'(20);

   function automatic uword_type mk(input rd_type rd, input wr_type wr, input act_type act,
                                    input cond_type cond, input logic [PC_W-1:0] target,
                                    input logic fin);
      uword_type w;
      w.rd     = rd;
      w.wr     = wr;
      w.act    = act;
      w.cond   = cond;
      w.target = target;
      w.fin    = fin;
      return w;
   endfunction

   // Control store. A step jumps to its target when its condition holds,
   // otherwise it falls through to the next address.
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         S_FETCH_A:  w = mk(RD_NODE_A, WR_NONE, ACT_NONE, C_NEVER, S_FETCH_A, 1'b0);
         S_FETCH_B:  w = mk(RD_NODE_B, WR_NONE, ACT_LATCH_A, C_NEVER, S_FETCH_A, 1'b0);
         S_SPLIT:    w = mk(RD_NONE, WR_NONE, ACT_LATCH_B, C_IS_QUERY, S_Q_CHECK, 1'b0);
         S_I_CHECK:  w = mk(RD_NONE, WR_NONE, ACT_NONE, C_ERR_INS, S_R_ERR, 1'b0);
         S_I_ROOT:   w = mk(RD_NONE, WR_ANC_B, ACT_NONE, C_NEVER, S_FETCH_A, 1'b0);
         S_I_READ:   w = mk(RD_ANC_B, WR_NONE, ACT_LVL_INC, C_NEVER, S_FETCH_A, 1'b0);
         S_I_WRITE:  w = mk(RD_NONE, WR_ANC_RD, ACT_B_FROM_RD, C_LVL_NOT_LAST, S_I_READ, 1'b0);
         S_I_FINISH: w = mk(RD_NONE, WR_NODE, ACT_RES_INS, C_ALWAYS, S_DONE, 1'b0);
         S_Q_CHECK:  w = mk(RD_NONE, WR_NONE, ACT_ORDER, C_ERR_QRY, S_R_ERR, 1'b0);
         S_L_TEST:   w = mk(RD_ANC_A, WR_NONE, ACT_LIFT_TEST, C_CLR_MORE, S_L_TEST, 1'b0);
         S_L_TAKE:   w = mk(RD_NONE, WR_NONE, ACT_LIFT_TAKE, C_MORE, S_L_TEST, 1'b0);
         S_P_EQ:     w = mk(RD_NONE, WR_NONE, ACT_LVL_TOP, C_A_EQ_B, S_R_SAME, 1'b0);
         S_P_TEST:   w = mk(RD_ANC_A, WR_NONE, ACT_NONE, C_SKIP, S_P_NEXT, 1'b0);
         S_P_READ_B: w = mk(RD_ANC_B, WR_NONE, ACT_CA_LATCH, C_NEVER, S_FETCH_A, 1'b0);
         S_P_CMP:    w = mk(RD_NONE, WR_NONE, ACT_MOVE, C_NEVER, S_FETCH_A, 1'b0);
         S_P_NEXT:   w = mk(RD_NONE, WR_NONE, ACT_LVL_DEC, C_LVL_NZ, S_P_TEST, 1'b0);
         S_P_PAR:    w = mk(RD_PAR_A, WR_NONE, ACT_NONE, C_NEVER, S_FETCH_A, 1'b0);
         S_P_RES:    w = mk(RD_NONE, WR_NONE, ACT_RES_PARENT, C_ALWAYS, S_DONE, 1'b0);
         S_R_SAME:   w = mk(RD_NONE, WR_NONE, ACT_RES_A, C_ALWAYS, S_DONE, 1'b0);
         S_R_ERR:    w = mk(RD_NONE, WR_NONE, ACT_RES_ERR, C_NEVER, S_FETCH_A, 1'b0);
         S_DONE:     w = mk(RD_NONE, WR_NONE, ACT_NONE, C_NEVER, S_FETCH_A, 1'b1);
         default:    w = mk(RD_NONE, WR_NONE, ACT_NONE, C_ALWAYS, S_R_ERR, 1'b0);
      endcase
      return w;
   endfunction

   // Row-major address of the 2^lvl-th ancestor entry of a node.
   function automatic logic [ANC_AW-1:0] anc_addr(input logic [NODE_W-1:0] node,
                                                  input logic [LVL_W-1:0] lvl);
      return ANC_AW'(node) * ANC_AW'(LEVELS) + ANC_AW'(lvl);
   endfunction

endpackage

`default_nettype wire

@@ hdl/lcal_ram.sv @@
`default_nettype none

module lcal_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/lcal_seq.sv @@
`default_nettype none

module lcal_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  lcal_pkg::flags_type   flags,
   output lcal_pkg::uword_type   uw,
   output logic                  busy
);

   logic                       run_ff, run_in;
   logic [lcal_pkg::PC_W-1:0]  pc_ff, pc_in;
   logic                       take;

   always_comb begin
      uw = run_ff ? lcal_pkg::ucode(pc_ff) : lcal_pkg::UW_NOP;
   end

   always_comb begin
      case (uw.cond)
         lcal_pkg::C_NEVER:        take = 1'b0;
         lcal_pkg::C_ALWAYS:       take = 1'b1;
         lcal_pkg::C_IS_QUERY:     take = flags.is_query;
         lcal_pkg::C_ERR_INS:      take = flags.err_ins;
         lcal_pkg::C_ERR_QRY:      take = flags.err_qry;
         lcal_pkg::C_LVL_NOT_LAST: take = flags.lvl_not_last;
         lcal_pkg::C_CLR_MORE:     take = flags.clr_more;
         lcal_pkg::C_MORE:         take = flags.more;
         lcal_pkg::C_A_EQ_B:       take = flags.a_eq_b;
         lcal_pkg::C_SKIP:         take = flags.skip;
         lcal_pkg::C_LVL_NZ:       take = flags.lvl_nz;
         default:                  take = 1'b0;
      endcase
   end

   always_comb begin
      run_in = run_ff;
      pc_in  = pc_ff;
      if (start) begin
         run_in = 1'b1;
         pc_in  = lcal_pkg::S_FETCH_A;
      end else if (run_ff) begin
         if (uw.fin) begin
            // The last step waits here until the output register is free.
            if (flags.out_free) begin
               run_in = 1'b0;
            end
         end else if (take) begin
            pc_in = uw.target;
         end else begin
            pc_in = pc_ff + lcal_pkg::PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pc_ff  <= lcal_pkg::S_FETCH_A;
      end else begin
         run_ff <= run_in;
         pc_ff  <= pc_in;
      end
   end

   assign busy = run_ff;

endmodule

`default_nettype wire

@@ hdl/lcal_dp.sv @@
`default_nettype none

module lcal_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_accept,
   input  logic                          req_op,
   input  logic [lcal_pkg::NODE_W-1:0]   req_node_a,
   input  logic [lcal_pkg::NODE_W-1:0]   req_node_b,
   input  lcal_pkg::uword_type           uw,
   output lcal_pkg::flags_type           flags,
   output logic                          clearing,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [lcal_pkg::NODE_W-1:0]   rsp_common_ancestor,
   output logic [lcal_pkg::DEPTH_W-1:0]  rsp_result_depth,
   output logic                          rsp_bad_request
);

   localparam int NODE_W  = lcal_pkg::NODE_W;
   localparam int DEPTH_W = lcal_pkg::DEPTH_W;
   localparam int LVL_W   = lcal_pkg::LVL_W;
   localparam int NODE_AW = lcal_pkg::NODE_AW;
   localparam int ANC_AW  = lcal_pkg::ANC_AW;

   // Working registers.
   logic                op_ff, op_in;
   logic [NODE_W-1:0]   a_ff, a_in, b_ff, b_in, ca_ff, ca_in;
   logic [DEPTH_W-1:0]  da_ff, da_in, db_ff, db_in, diff_ff, diff_in;
   logic                la_ff, la_in, lb_ff, lb_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic                hit_ff, hit_in, last_ff, last_in;
   logic [NODE_W-1:0]   res_node_ff, res_node_in;
   logic [DEPTH_W-1:0]  res_depth_ff, res_depth_in;
   logic                res_bad_ff, res_bad_in;

   // Output register and reset clearing pass.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0]   rsp_ca_ff;
   logic [DEPTH_W-1:0]  rsp_depth_ff;
   logic                rsp_bad_ff;
   logic                clr_ff, clr_in;
   logic [NODE_AW-1:0]  clr_cnt_ff, clr_cnt_in;

   // Memory ports.
   logic                node_we;
   logic [NODE_AW-1:0]  node_waddr, node_raddr;
   logic [DEPTH_W:0]    node_wdata, node_rd;
   logic                anc_we;
   logic [ANC_AW-1:0]   anc_waddr, anc_raddr;
   logic [NODE_W-1:0]   anc_wdata, anc_rd, anc_masked;

   logic [DEPTH_W-1:0]  pow2;
   logic                out_free, rsp_load;

   // Node store: loaded flag on top of the depth.
   lcal_ram #(
      .WIDTH (DEPTH_W + 1),
      .DEPTH (lcal_pkg::NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .wr_addr (node_waddr),
      .wr_data (node_wdata),
      .rd_addr (node_raddr),
      .rd_data (node_rd)
   );

   lcal_ram #(
      .WIDTH (NODE_W),
      .DEPTH (lcal_pkg::ANC_SIZE)
   ) u_anc_ram (
      .clock   (clock),
      .wr_en   (anc_we),
      .wr_addr (anc_waddr),
      .wr_data (anc_wdata),
      .rd_addr (anc_raddr),
      .rd_data (anc_rd)
   );

   // The row of the sentinel node is never written; it reads as all zero.
   assign anc_masked = (b_ff == '0) ? '0 : anc_rd;
   assign pow2       = DEPTH_W'(1) << lvl_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_load   = uw.fin && out_free;

   always_comb begin
      case (uw.rd)
         lcal_pkg::RD_NODE_A: node_raddr = a_ff;
         lcal_pkg::RD_NODE_B: node_raddr = b_ff;
         default:             node_raddr = a_ff;
      endcase
      case (uw.rd)
         lcal_pkg::RD_ANC_B:  anc_raddr = lcal_pkg::anc_addr(b_ff, lvl_ff);
         lcal_pkg::RD_PAR_A:  anc_raddr = lcal_pkg::anc_addr(a_ff, '0);
         default:             anc_raddr = lcal_pkg::anc_addr(a_ff, lvl_ff);
      endcase
   end

   always_comb begin
      anc_waddr = lcal_pkg::anc_addr(a_ff, lvl_ff);
      anc_we    = 1'b0;
      anc_wdata = b_ff;
      node_we    = 1'b0;
      node_waddr = a_ff;
      node_wdata = {1'b1, db_ff + DEPTH_W'(1)};
      if (clr_ff) begin
         node_we    = 1'b1;
         node_waddr = clr_cnt_ff;
         node_wdata = '0;
      end else begin
         case (uw.wr)
            lcal_pkg::WR_ANC_B: begin
               anc_we = 1'b1;
            end
            lcal_pkg::WR_ANC_RD: begin
               anc_we    = 1'b1;
               anc_wdata = anc_masked;
            end
            lcal_pkg::WR_NODE: begin
               node_we = 1'b1;
            end
            default: begin
               anc_we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      op_in        = op_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      ca_in        = ca_ff;
      da_in        = da_ff;
      db_in        = db_ff;
      diff_in      = diff_ff;
      la_in        = la_ff;
      lb_in        = lb_ff;
      lvl_in       = lvl_ff;
      hit_in       = hit_ff;
      last_in      = last_ff;
      res_node_in  = res_node_ff;
      res_depth_in = res_depth_ff;
      res_bad_in   = res_bad_ff;
      if (req_accept) begin
         op_in  = req_op;
         a_in   = req_node_a;
         b_in   = req_node_b;
         lvl_in = '0;
      end else begin
         case (uw.act)
            lcal_pkg::ACT_LATCH_A: begin
               la_in = node_rd[DEPTH_W];
               da_in = node_rd[DEPTH_W-1:0];
            end
            lcal_pkg::ACT_LATCH_B: begin
               lb_in = node_rd[DEPTH_W];
               db_in = node_rd[DEPTH_W-1:0];
            end
            lcal_pkg::ACT_LVL_INC: begin
               lvl_in = lvl_ff + LVL_W'(1);
            end
            lcal_pkg::ACT_B_FROM_RD: begin
               b_in = anc_masked;
            end
            lcal_pkg::ACT_RES_INS: begin
               res_node_in  = '0;
               res_depth_in = db_ff + DEPTH_W'(1);
               res_bad_in   = 1'b0;
            end
            lcal_pkg::ACT_ORDER: begin
               // Put the deeper node in a and keep the depth gap to lift.
               lvl_in = LVL_W'(lcal_pkg::LEVELS - 1);
               if (da_ff < db_ff) begin
                  a_in    = b_ff;
                  b_in    = a_ff;
                  da_in   = db_ff;
                  db_in   = da_ff;
                  diff_in = db_ff - da_ff;
               end else begin
                  diff_in = da_ff - db_ff;
               end
            end
            lcal_pkg::ACT_LIFT_TEST: begin
               hit_in  = diff_ff[lvl_ff];
               last_in = (lvl_ff == '0);
               lvl_in  = lvl_ff - LVL_W'(1);
            end
            lcal_pkg::ACT_LIFT_TAKE: begin
               if (hit_ff) begin
                  a_in = anc_rd;
               end
            end
            lcal_pkg::ACT_LVL_TOP: begin
               lvl_in = LVL_W'(lcal_pkg::LEVELS - 1);
               da_in  = db_ff;
            end
            lcal_pkg::ACT_CA_LATCH: begin
               ca_in = anc_rd;
            end
            lcal_pkg::ACT_MOVE: begin
               if (ca_ff != anc_rd) begin
                  a_in  = ca_ff;
                  b_in  = anc_rd;
                  da_in = da_ff - pow2;
               end
            end
            lcal_pkg::ACT_LVL_DEC: begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
            lcal_pkg::ACT_RES_PARENT: begin
               res_node_in  = anc_rd;
               res_depth_in = da_ff - DEPTH_W'(1);
               res_bad_in   = 1'b0;
            end
            lcal_pkg::ACT_RES_A: begin
               res_node_in  = a_ff;
               res_depth_in = da_ff;
               res_bad_in   = 1'b0;
            end
            lcal_pkg::ACT_RES_ERR: begin
               res_node_in  = '0;
               res_depth_in = '0;
               res_bad_in   = 1'b1;
            end
            default: begin
               op_in = op_ff;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      clr_in     = clr_ff;
      clr_cnt_in = clr_cnt_ff;
      if (clr_ff) begin
         clr_cnt_in = clr_cnt_ff + NODE_AW'(1);
         if (clr_cnt_ff == NODE_AW'(lcal_pkg::NODES - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         clr_cnt_ff   <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      ca_ff        <= ca_in;
      da_ff        <= da_in;
      db_ff        <= db_in;
      diff_ff      <= diff_in;
      la_ff        <= la_in;
      lb_ff        <= lb_in;
      lvl_ff       <= lvl_in;
      hit_ff       <= hit_in;
      last_ff      <= last_in;
      res_node_ff  <= res_node_in;
      res_depth_ff <= res_depth_in;
      res_bad_ff   <= res_bad_in;
      if (rsp_load) begin
         rsp_ca_ff    <= res_node_ff;
         rsp_depth_ff <= res_depth_ff;
         rsp_bad_ff   <= res_bad_ff;
      end
   end

   always_comb begin
      flags.is_query     = op_ff;
      flags.err_ins      = (a_ff == '0) || la_ff || ((b_ff != '0) && !lb_ff);
      flags.err_qry      = !la_ff || !lb_ff;
      flags.lvl_not_last = (lvl_ff != LVL_W'(lcal_pkg::LEVELS - 1));
      flags.clr_more     = !diff_ff[lvl_ff] && (lvl_ff != '0);
      flags.more         = !last_ff;
      flags.a_eq_b       = (a_ff == b_ff);
      // Above the root both ancestors are the sentinel, so that level is skipped.
      flags.skip         = (da_ff <= pow2);
      flags.lvl_nz       = (lvl_ff != '0);
      flags.out_free     = out_free;
   end

   assign clearing            = clr_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_common_ancestor = rsp_ca_ff;
   assign rsp_result_depth    = rsp_depth_ff;
   assign rsp_bad_request     = rsp_bad_ff;

endmodule

`default_nettype wire

@@ hdl/lowest_common_ancestor_lifting.sv @@
// Query time is set by the dependent ancestor-table reads, one per level
// and node, through a single read port.
// One transaction at a time; the next is accepted once the result is registered.
// Synchronous reset; afterwards the node store is cleared, during which no
// request is accepted.
`default_nettype none

module lowest_common_ancestor_lifting (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [lcal_pkg::NODE_W-1:0]   req_node_a,
   input  logic [lcal_pkg::NODE_W-1:0]   req_node_b,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lcal_pkg::NODE_W-1:0]   rsp_common_ancestor,
   output logic [lcal_pkg::DEPTH_W-1:0]  rsp_result_depth,
   output logic                          rsp_bad_request
);

   lcal_pkg::uword_type  uw;
   lcal_pkg::flags_type  flags;
   logic                 seq_busy;
   logic                 dp_clearing;
   logic                 req_accept;

   assign req_ready  = !seq_busy && !dp_clearing;
   assign req_accept = req_valid && req_ready;

   lcal_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (req_accept),
      .flags (flags),
      .uw    (uw),
      .busy  (seq_busy)
   );

   lcal_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .req_accept          (req_accept),
      .req_op              (req_op),
      .req_node_a          (req_node_a),
      .req_node_b          (req_node_b),
      .uw                  (uw),
      .flags               (flags),
      .clearing            (dp_clearing),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_common_ancestor (rsp_common_ancestor),
      .rsp_result_depth    (rsp_result_depth),
      .rsp_bad_request     (rsp_bad_request)
   );

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (seq_busy && !req_ready))
      else $error("accepted transaction did not start the sequencer");

   a_result_from_seq: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(seq_busy) && !seq_busy))
      else $error("result appeared without the sequencer finishing");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_bad_request) |->
         (rsp_common_ancestor == '0 && rsp_result_depth == '0))
      else $error("refused transaction carries nonzero fields");

   a_depth_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_request && rsp_common_ancestor != '0) |->
         (rsp_result_depth != '0))
      else $error("loaded ancestor reported with depth zero");

endmodule

`default_nettype wire
